// ===== rtl/lpdm_pkg.sv =====
`timescale 1ns / 1ps
package lpdm_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;
    localparam int RowW     = 9;
    localparam int ColW     = 10;
    localparam int DepthW   = 31;
    localparam int CoordW   = 12;
    localparam int SizeW    = 13;
    localparam int RemW     = 57;
    localparam int DenW     = 43;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FOCAL_X      = 3'd0,
        CFG_FOCAL_Y      = 3'd1,
        CFG_CENTER_X     = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic              kind;
        logic              ok;
        logic [DepthW-1:0] depth;
        logic [RowW-1:0]   rrow;
        logic [ColW-1:0]   rcol;
        logic [RemW-1:0]   remx;
        logic [RemW-1:0]   remy;
        logic [DenW-1:0]   den;
        logic [CoordW-1:0] qx;
        logic [CoordW-1:0] qy;
    } t_div_item;

endpackage

// ===== rtl/lpdm_in_if.sv =====
`timescale 1ns / 1ps
interface lpdm_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic [8:0]  read_row;
    logic [9:0]  read_col;

    modport source (output valid, kind, point_x, point_y, point_z, read_row, read_col,
                    input ready);
    modport sink (input valid, kind, point_x, point_y, point_z, read_row, read_col,
                  output ready);
endinterface

// ===== rtl/lpdm_out_if.sv =====
`timescale 1ns / 1ps
interface lpdm_out_if;
    logic        valid;
    logic        ready;
    logic        landed;
    logic [8:0]  pixel_row;
    logic [9:0]  pixel_col;
    logic [30:0] depth_out;
    logic        depth_valid;

    modport source (output valid, landed, pixel_row, pixel_col, depth_out, depth_valid,
                    input ready);
    modport sink (input valid, landed, pixel_row, pixel_col, depth_out, depth_valid,
                  output ready);
endinterface

// ===== rtl/lpdm_front.sv =====
`timescale 1ns / 1ps
module lpdm_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lpdm_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [lpdm_pkg::CfgDataW-1:0]     i_cfg_data,
    input  logic                              i_valid,
    input  logic                              i_kind,
    input  logic signed [31:0]                i_point_x,
    input  logic signed [31:0]                i_point_y,
    input  logic signed [31:0]                i_point_z,
    input  logic [lpdm_pkg::RowW-1:0]         i_read_row,
    input  logic [lpdm_pkg::ColW-1:0]         i_read_col,
    input  logic                              i_down_en,
    output logic                              o_up_en,
    output logic                              o_valid,
    output lpdm_pkg::t_div_item               o_item
);

    localparam int SW = lpdm_pkg::SizeW;
    localparam logic [SW-1:0] WRst = SW'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
    localparam logic [SW-1:0] HRst = SW'((MAX_HEIGHT < 512) ? MAX_HEIGHT : 512);

    logic [23:0]   r_fx, r_fy, r_cx, r_cy;
    logic [SW-1:0] r_wsz, r_hsz;
    logic [SW-1:0] n_wsz, n_hsz;

    logic en1, en2, en3;
    logic r_v1, r_v2, r_v3;

    logic                              r_k1, r_zp1, r_nz1;
    logic [lpdm_pkg::DepthW-1:0]       r_d1;
    logic [lpdm_pkg::RowW-1:0]         r_rr1;
    logic [lpdm_pkg::ColW-1:0]         r_rc1;
    logic signed [56:0]                r_px1, r_cxz1, r_py1, r_cyz1;
    logic signed [45:0]                r_lx1, r_ly1;

    logic                              r_k2, r_ok2;
    logic [lpdm_pkg::DepthW-1:0]       r_d2;
    logic [lpdm_pkg::RowW-1:0]         r_rr2;
    logic [lpdm_pkg::ColW-1:0]         r_rc2;
    logic signed [57:0]                r_nx2, r_ny2, r_lx2, r_ly2;

    lpdm_pkg::t_div_item               r_it3, n_it3;
    logic [SW-1:0]                     wm1, hm1;

    assign n_wsz = (SW'(i_cfg_data[10:0]) > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH)
                                                            : SW'(i_cfg_data[10:0]);
    assign n_hsz = (SW'(i_cfg_data[9:0]) > SW'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT)
                                                            : SW'(i_cfg_data[9:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx  <= 24'd2097152;
            r_fy  <= 24'd2097152;
            r_cx  <= 24'd2097152;
            r_cy  <= 24'd1048576;
            r_wsz <= WRst;
            r_hsz <= HRst;
        end else if (i_cfg_we) begin
            case (lpdm_pkg::t_cfg_idx'(i_cfg_idx))
                lpdm_pkg::CFG_FOCAL_X:      r_fx  <= i_cfg_data;
                lpdm_pkg::CFG_FOCAL_Y:      r_fy  <= i_cfg_data;
                lpdm_pkg::CFG_CENTER_X:     r_cx  <= i_cfg_data;
                lpdm_pkg::CFG_CENTER_Y:     r_cy  <= i_cfg_data;
                lpdm_pkg::CFG_IMAGE_WIDTH:  r_wsz <= n_wsz;
                lpdm_pkg::CFG_IMAGE_HEIGHT: r_hsz <= n_hsz;
                default: ;
            endcase
        end
    end

    assign en3     = !r_v3 || i_down_en;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_up_en = en1;
    assign o_valid = r_v3;
    assign o_item  = r_it3;

    assign wm1 = r_wsz - SW'(1);
    assign hm1 = r_hsz - SW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_k1   <= i_kind;
            r_d1   <= i_point_z[30:0];
            r_rr1  <= i_read_row;
            r_rc1  <= i_read_col;
            r_zp1  <= (i_point_z > 32'sd0);
            r_nz1  <= (r_wsz != '0) && (r_hsz != '0);
            r_px1  <= $signed({1'b0, r_fx}) * i_point_x;
            r_cxz1 <= $signed({1'b0, r_cx}) * i_point_z;
            r_py1  <= $signed({1'b0, r_fy}) * i_point_y;
            r_cyz1 <= $signed({1'b0, r_cy}) * i_point_z;
            r_lx1  <= $signed({1'b0, wm1}) * i_point_z;
            r_ly1  <= $signed({1'b0, hm1}) * i_point_z;
        end
        if (en2) begin
            r_k2  <= r_k1;
            r_d2  <= r_d1;
            r_rr2 <= r_rr1;
            r_rc2 <= r_rc1;
            r_ok2 <= r_zp1 && r_nz1 && !r_k1;
            r_nx2 <= 58'(r_px1) + 58'(r_cxz1);
            r_ny2 <= 58'(r_py1) + 58'(r_cyz1);
            r_lx2 <= 58'(r_lx1) <<< 12;
            r_ly2 <= 58'(r_ly1) <<< 12;
        end
        if (en3) begin
            r_it3 <= n_it3;
        end
    end

    always_comb begin
        n_it3.kind  = r_k2;
        n_it3.ok    = r_ok2 && !r_nx2[57] && (r_nx2 <= r_lx2)
                            && !r_ny2[57] && (r_ny2 <= r_ly2);
        n_it3.depth = r_d2;
        n_it3.rrow  = r_rr2;
        n_it3.rcol  = r_rc2;
        n_it3.remx  = r_nx2[56:0];
        n_it3.remy  = r_ny2[56:0];
        n_it3.den   = {r_d2, 12'd0};
        n_it3.qx    = '0;
        n_it3.qy    = '0;
    end

endmodule

// ===== rtl/lpdm_div_stage.sv =====
`timescale 1ns / 1ps
module lpdm_div_stage #(
    parameter int BIT = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  lpdm_pkg::t_div_item i_item,
    input  logic                i_down_en,
    output logic                o_up_en,
    output logic                o_valid,
    output lpdm_pkg::t_div_item o_item
);

    localparam int RW = lpdm_pkg::RemW;

    logic                r_v;
    lpdm_pkg::t_div_item r_it, n_it;
    logic [RW-1:0]       trial;
    logic                gex, gey;

    assign o_up_en = !r_v || i_down_en;
    assign o_valid = r_v;
    assign o_item  = r_it;

    assign trial = RW'(i_item.den) << BIT;
    assign gex   = i_item.remx >= trial;
    assign gey   = i_item.remy >= trial;

    always_comb begin
        n_it = i_item;
        if (gex) begin
            n_it.remx    = i_item.remx - trial;
            n_it.qx[BIT] = 1'b1;
        end
        if (gey) begin
            n_it.remy    = i_item.remy - trial;
            n_it.qy[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_up_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_en) begin
            r_it <= n_it;
        end
    end

endmodule

// ===== rtl/lpdm_store.sv =====
`timescale 1ns / 1ps
module lpdm_store #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  lpdm_pkg::t_div_item i_item,
    output logic                o_up_en,
    output logic                o_busy,
    lpdm_out_if.source          o_res
);

    localparam int Cells = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(Cells);
    localparam int SW    = lpdm_pkg::SizeW;
    localparam int CW    = lpdm_pkg::CoordW;

    logic [31:0] r_mem [Cells];
    logic [31:0] r_rd;

    logic          r_busy;
    logic [AW-1:0] r_clr;

    logic                        en_a, en_b;
    logic                        r_va, r_wea, r_rea, r_landa;
    logic [lpdm_pkg::RowW-1:0]   r_rowa;
    logic [lpdm_pkg::ColW-1:0]   r_cola;
    logic [AW-1:0]               r_addra;
    logic [lpdm_pkg::DepthW-1:0] r_depa;

    logic                        r_vb, r_landb, r_rdokb;
    logic [lpdm_pkg::RowW-1:0]   r_rowb;
    logic [lpdm_pkg::ColW-1:0]   r_colb;

    logic [CW-1:0]               row_c, col_c;
    logic                        n_rdok;
    logic [lpdm_pkg::RowW-1:0]   n_row;
    logic [lpdm_pkg::ColW-1:0]   n_col;

    logic          mwe, mre;
    logic [AW-1:0] maddr;
    logic [31:0]   mdata;

    assign en_b    = !r_vb || o_res.ready;
    assign en_a    = !r_va || en_b;
    assign o_up_en = en_a;
    assign o_busy  = r_busy;

    assign row_c  = i_item.kind ? CW'(i_item.rrow) : i_item.qy;
    assign col_c  = i_item.kind ? CW'(i_item.rcol) : i_item.qx;
    assign n_rdok = i_item.kind && (SW'(i_item.rrow) < SW'(MAX_HEIGHT))
                                && (SW'(i_item.rcol) < SW'(MAX_WIDTH));
    assign n_row  = i_item.kind ? i_item.rrow
                  : (i_item.ok ? i_item.qy[lpdm_pkg::RowW-1:0] : '0);
    assign n_col  = i_item.kind ? i_item.rcol
                  : (i_item.ok ? i_item.qx[lpdm_pkg::ColW-1:0] : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va   <= 1'b0;
            r_vb   <= 1'b0;
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
            if (r_busy) begin
                r_clr <= r_clr + AW'(1);
                if (r_clr == AW'(Cells - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_wea   <= i_item.ok && !i_item.kind;
            r_rea   <= n_rdok;
            r_landa <= i_item.ok && !i_item.kind;
            r_rowa  <= n_row;
            r_cola  <= n_col;
            r_addra <= AW'(32'(row_c) * MAX_WIDTH + 32'(col_c));
            r_depa  <= i_item.depth;
        end
        if (en_b) begin
            r_landb <= r_landa;
            r_rowb  <= r_rowa;
            r_colb  <= r_cola;
            r_rdokb <= r_rea;
        end
    end

    assign mwe   = r_busy || (en_b && r_va && r_wea);
    assign mre   = en_b && r_va && r_rea;
    assign maddr = r_busy ? r_clr : r_addra;
    assign mdata = r_busy ? 32'd0 : {1'b1, r_depa};

    always_ff @(posedge i_clk) begin
        if (mwe) begin
            r_mem[maddr] <= mdata;
        end
        if (mre) begin
            r_rd <= r_mem[r_addra];
        end
    end

    assign o_res.valid       = r_vb;
    assign o_res.landed      = r_landb;
    assign o_res.pixel_row   = r_rowb;
    assign o_res.pixel_col   = r_colb;
    assign o_res.depth_valid = r_rdokb && r_rd[31];
    assign o_res.depth_out   = (r_rdokb && r_rd[31]) ? r_rd[30:0] : '0;

endmodule

// ===== rtl/lidar_point_depth_map_projection.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle while o_res.ready is high and no clear pass runs;
// one quotient bit per divider stage per axis.
// Reset: synchronous, active low; restores register defaults and empties the pipeline.
// After reset a clear pass resets the written flags of all MAX_WIDTH*MAX_HEIGHT cells;
// no item is accepted until it ends, configuration writes still are.
module lidar_point_depth_map_projection #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lpdm_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [lpdm_pkg::CfgDataW-1:0] i_cfg_data,
    lpdm_in_if.sink                       i_pt,
    lpdm_out_if.source                    o_res
);

    localparam int QB = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);

    logic                busy;
    logic                front_en;
    logic                dv    [QB+1];
    lpdm_pkg::t_div_item ditem [QB+1];
    logic                den   [QB+1];

    assign i_pt.ready = front_en && !busy;

    lpdm_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_pt.valid && !busy),
        .i_kind    (i_pt.kind),
        .i_point_x (i_pt.point_x),
        .i_point_y (i_pt.point_y),
        .i_point_z (i_pt.point_z),
        .i_read_row(i_pt.read_row),
        .i_read_col(i_pt.read_col),
        .i_down_en (den[0]),
        .o_up_en   (front_en),
        .o_valid   (dv[0]),
        .o_item    (ditem[0])
    );

    for (genvar g = 0; g < QB; g++) begin : g_div
        lpdm_div_stage #(
            .BIT(QB - 1 - g)
        ) u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (dv[g]),
            .i_item   (ditem[g]),
            .i_down_en(den[g+1]),
            .o_up_en  (den[g]),
            .o_valid  (dv[g+1]),
            .o_item   (ditem[g+1])
        );
    end

    lpdm_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_store (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(dv[QB]),
        .i_item (ditem[QB]),
        .o_up_en(den[QB]),
        .o_busy (busy),
        .o_res  (o_res)
    );

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !i_pt.ready)
        else $error("item accepted during flag clear");

    a_landed_no_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.landed) |-> !o_res.depth_valid)
        else $error("stored point reports read depth");

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !busy)
        else $error("flag clear restarted without reset");
`endif

endmodule

// ===== verif/lidar_point_depth_map_projection_tb.sv =====
`timescale 1ns / 1ps
module lidar_point_depth_map_projection_tb;
    import lpdm_pkg::*;

    localparam logic [CfgIdxW-1:0] CFG_SPARE = 3'd7;
    localparam int CELL_COLS = 1024;
    localparam int CELL_ROWS = 512;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        bit          landed;
        bit [8:0]    row;
        bit [9:0]    col;
        bit [30:0]   depth;
        bit          dvalid;
    } t_pixel_res;

    class depth_map_scoreboard;
        int unsigned focal_x, focal_y, center_x, center_y, width, height;
        bit [30:0]   depth_mem[int];
        bit          written[int];
        int          hit_rows[$];
        int          hit_cols[$];
        t_pixel_res  pending[$];
        int          errors;

        function void restore_defaults();
            focal_x = 2097152;
            focal_y = 2097152;
            center_x = 2097152;
            center_y = 1048576;
            width = 1024;
            height = 512;
        endfunction

        function void write_reg(t_cfg_idx idx, int unsigned value);
            case (idx)
                CFG_FOCAL_X:      focal_x = value & 24'hFFFFFF;
                CFG_FOCAL_Y:      focal_y = value & 24'hFFFFFF;
                CFG_CENTER_X:     center_x = value & 24'hFFFFFF;
                CFG_CENTER_Y:     center_y = value & 24'hFFFFFF;
                CFG_IMAGE_WIDTH:  width = value & 11'h7FF;
                CFG_IMAGE_HEIGHT: height = value & 10'h3FF;
                default: ;
            endcase
        endfunction

        function bit project_axis(longint f, longint c, longint p, longint z, longint size,
                                  output int coord);
            longint num;
            longint den;
            num = f * p + c * z;
            den = z * 4096;
            coord = 0;
            if (size == 0 || num < 0) return 0;
            if (num > (size - 1) * den) return 0;
            coord = int'(num / den);
            return 1;
        endfunction

        function void note(bit kind, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [8:0] rrow, logic [9:0] rcol);
            t_pixel_res r;
            longint     z;
            int         col;
            int         row;
            int         w;
            int         h;
            int         key;
            r = '{0, 0, 0, 0, 0};
            if (!kind) begin
                z = longint'(signed'(pz));
                w = (width > CELL_COLS) ? CELL_COLS : width;
                h = (height > CELL_ROWS) ? CELL_ROWS : height;
                if (z > 0 &&
                    project_axis(focal_x, center_x, longint'(signed'(px)), z, w, col) &&
                    project_axis(focal_y, center_y, longint'(signed'(py)), z, h, row)) begin
                    key = row * CELL_COLS + col;
                    depth_mem[key] = pz[30:0];
                    written[key] = 1;
                    hit_rows.push_back(row);
                    hit_cols.push_back(col);
                    r.landed = 1;
                    r.row = row[8:0];
                    r.col = col[9:0];
                end
            end else begin
                r.row = rrow;
                r.col = rcol;
                key = int'(rrow) * CELL_COLS + int'(rcol);
                if (written.exists(key)) begin
                    r.dvalid = 1;
                    r.depth = depth_mem[key];
                end
            end
            pending.push_back(r);
        endfunction

        function void check(logic landed, logic [8:0] row, logic [9:0] col,
                            logic [30:0] depth, logic dvalid);
            t_pixel_res e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: landed=%0b row=%0d col=%0d depth=%0h valid=%0b",
                             landed, row, col, depth, dvalid);
                return;
            end
            e = pending.pop_front();
            if (landed !== e.landed || row !== e.row || col !== e.col ||
                depth !== e.depth || dvalid !== e.dvalid) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp landed=%0b row=%0d col=%0d depth=%0h valid=%0b, got landed=%0b row=%0d col=%0d depth=%0h valid=%0b",
                             e.landed, e.row, e.col, e.depth, e.dvalid,
                             landed, row, col, depth, dvalid);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    lpdm_in_if  pt_ch();
    lpdm_out_if res_ch();

    lidar_point_depth_map_projection i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_ch.sink),
        .o_res      (res_ch.source)
    );

    depth_map_scoreboard sb;
    bit     calm;
    bit     hold_req;
    longint cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("lidar_point_depth_map_projection_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pt_ch.valid && pt_ch.ready)
            sb.note(pt_ch.kind, pt_ch.point_x, pt_ch.point_y, pt_ch.point_z,
                    pt_ch.read_row, pt_ch.read_col);
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check(res_ch.landed, res_ch.pixel_row, res_ch.pixel_col,
                     res_ch.depth_out, res_ch.depth_valid);
    end

    initial begin
        int n;
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 13);
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic set_reg(t_cfg_idx idx, int unsigned value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[CfgDataW-1:0];
        sb.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic set_spare(int unsigned value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_SPARE;
        i_cfg_data <= value[CfgDataW-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_camera(int unsigned fx, int unsigned fy, int unsigned cx,
                              int unsigned cy, int unsigned w, int unsigned h);
        set_reg(CFG_FOCAL_X, fx);
        set_reg(CFG_FOCAL_Y, fy);
        set_reg(CFG_CENTER_X, cx);
        set_reg(CFG_CENTER_Y, cy);
        set_reg(CFG_IMAGE_WIDTH, w);
        set_reg(CFG_IMAGE_HEIGHT, h);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push(bit kind, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                        logic [8:0] rrow, logic [9:0] rcol);
        int n;
        pt_ch.valid <= 1'b1;
        pt_ch.kind <= kind;
        pt_ch.point_x <= px;
        pt_ch.point_y <= py;
        pt_ch.point_z <= pz;
        pt_ch.read_row <= rrow;
        pt_ch.read_col <= rcol;
        do @(posedge i_clk); while (!pt_ch.ready);
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 13);
            pt_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        pt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // aim one axis at a pixel, slightly beyond the image edges now and then
    function automatic logic [31:0] aim(longint f, longint c, longint size, longint z);
        longint target;
        longint v;
        if (f == 0 || size == 0) return $urandom;
        target = longint'($urandom_range(0, int'(size) * 4096 * 5 / 4)) - size * 512;
        v = (target - c) * z / f;
        if (v > 64'sh7FFFFFFF || v < -64'sh80000000) return $urandom;
        return v[31:0];
    endfunction

    task automatic random_item();
        int       sel;
        int       k;
        longint   z;
        logic [31:0] zz;
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            push($urandom_range(0, 1), $urandom, $urandom, $urandom,
                 $urandom, $urandom);
        end else if (sel < 55) begin
            z = (sel < 50) ? longint'($urandom_range(1, 32'h0100_0000)) : longint'($urandom_range(1, 32'h7FFF_FFFF));
            zz = z[31:0];
            push(1'b0, aim(sb.focal_x, sb.center_x,
                           (sb.width > CELL_COLS) ? CELL_COLS : sb.width, z),
                 aim(sb.focal_y, sb.center_y,
                     (sb.height > CELL_ROWS) ? CELL_ROWS : sb.height, z),
                 zz, $urandom, $urandom);
        end else if (sel < 85 && sb.hit_rows.size() != 0) begin
            k = $urandom_range(0, sb.hit_rows.size() - 1);
            push(1'b1, $urandom, $urandom, $urandom, sb.hit_rows[k], sb.hit_cols[k]);
        end else begin
            push(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic random_run(int n, bit calm_tail);
        for (int i = 0; i < n; i++) begin
            if (calm_tail && i == n / 2) calm = 1;
            if (i == n / 3 && !calm_tail) hold_req = 1;
            random_item();
        end
        drain();
    endtask

    initial begin
        sb = new();
        sb.restore_defaults();
        calm = 0;
        hold_req = 0;
        cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        pt_ch.valid = 1'b0;
        pt_ch.kind = 1'b0;
        pt_ch.point_x = '0;
        pt_ch.point_y = '0;
        pt_ch.point_z = '0;
        pt_ch.read_row = '0;
        pt_ch.read_col = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push(1'b1, 32'h0, 32'h0, 32'h0, 9'd256, 10'd512);
        push(1'b0, 32'h0, 32'h0, 32'h0001_0000, 9'd0, 10'd0);
        push(1'b1, 32'h0, 32'h0, 32'h0, 9'd256, 10'd512);
        push(1'b0, 32'h0, 32'h0, 32'h7FFF_FFFF, 9'd0, 10'd0);
        push(1'b1, 32'h0, 32'h0, 32'h0, 9'd256, 10'd512);
        push(1'b0, 32'h0, 32'h0, 32'h0, 9'h1FF, 10'h3FF);
        push(1'b0, 32'h0, 32'h0, 32'hFFFF_0000, 9'd0, 10'd0);
        push(1'b0, 32'h0, 32'h0, 32'h8000_0000, 9'd0, 10'd0);
        push(1'b0, 32'h8000_0000, 32'h0, 32'h0001_0000, 9'd0, 10'd0);
        push(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 9'd0, 10'd0);
        push(1'b0, 32'hFFFF_0000, 32'hFFFF_8000, 32'h0001_0000, 9'd0, 10'd0);
        push(1'b0, 32'h01FF_0000, 32'h00FF_0000, 32'h0200_0000, 9'd0, 10'd0);
        push(1'b0, 32'h0200_0000, 32'h0, 32'h0200_0000, 9'd0, 10'd0);
        push(1'b0, 32'h0, 32'h0100_0000, 32'h0200_0000, 9'd0, 10'd0);
        push(1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 9'd0, 10'd0);
        push(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd0, 10'd0);
        push(1'b1, 32'h0, 32'h0, 32'h0, 9'd511, 10'd1023);
        push(1'b1, 32'h0, 32'h0, 32'h0, 9'd0, 10'd1023);
        push(1'b1, 32'h0, 32'h0, 32'h0, 9'd255, 10'd0);
        push(1'b0, 32'h0, 32'h0, 32'h0002_0000, 9'd0, 10'd0);
        push(1'b1, 32'h0, 32'h0, 32'h0, 9'd256, 10'd512);
        push(1'b1, 32'h0, 32'h0, 32'h0, 9'd3, 10'd7);
        drain();

        random_run(500, 0);

        set_camera($urandom_range(16, 2048) << 12, $urandom_range(16, 2048) << 12,
                   $urandom_range(0, 1024 << 12), $urandom_range(0, 512 << 12),
                   $urandom_range(1, 1024), $urandom_range(1, 512));
        random_run(300, 0);

        set_camera(24'hFFFFFF, 24'hFFFFFF, 0, 0, 11'h7FF, 10'h3FF);
        random_run(250, 0);

        set_spare(24'hFFFFFF);
        set_camera(0, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 512);
        random_run(100, 0);

        set_camera(1 << 12, 24'hFFFFFF, 24'hFFFFFF, 0, 1, 0);
        random_run(100, 0);

        set_camera($urandom_range(1, 24'hFFFFFF), $urandom_range(1, 24'hFFFFFF),
                   $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                   1, 1);
        random_run(100, 0);

        set_camera(2097152, 2097152, 2097152, 1048576, 1024, 512);
        random_run(450, 1);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("lidar_point_depth_map_projection_tb passed");
        end else begin
            $display("lidar_point_depth_map_projection_tb failed");
        end
        $finish;
    end
endmodule
